>>> hdl/aalu_pkg.sv
package aalu_pkg;

  localparam int unsigned CmdWidth  = 5;
  localparam int unsigned DataWidth = 8;
  localparam int unsigned NibWidth  = 4;

  // Data word packing on both streams, zero-filled to whole bytes
  localparam int unsigned InTdataWidth  = 16;
  localparam int unsigned OutTdataWidth = 16;

  localparam logic [DataWidth-1:0] DaaLowCorr  = 8'h06;
  localparam logic [DataWidth-1:0] DaaHighCorr = 8'h60;
  localparam logic [DataWidth-1:0] DaaHighMax  = 8'h99;
  localparam logic [NibWidth-1:0]  DaaLowMax   = 4'h9;

  typedef enum logic [CmdWidth-1:0] {
    CMD_ADD  = 5'd0,
    CMD_ADC  = 5'd1,
    CMD_SUB  = 5'd2,
    CMD_SBC  = 5'd3,
    CMD_AND  = 5'd4,
    CMD_XOR  = 5'd5,
    CMD_OR   = 5'd6,
    CMD_CP   = 5'd7,
    CMD_DAA  = 5'd8,
    CMD_CPL  = 5'd9,
    CMD_SCF  = 5'd10,
    CMD_CCF  = 5'd11,
    CMD_RLCA = 5'd12,
    CMD_RLA  = 5'd13,
    CMD_RRCA = 5'd14,
    CMD_RRA  = 5'd15,
    CMD_LOAD = 5'd16
  } cmd_e;

  typedef struct packed {
    logic zero;
    logic sub;
    logic half;
    logic carry;
  } flags_t;

endpackage

>>> hdl/aalu_exec.sv
module aalu_exec
  import aalu_pkg::*;
(
  input  logic [CmdWidth-1:0]  cmd_i,
  input  logic [DataWidth-1:0] operand_i,
  input  logic [DataWidth-1:0] acc_i,
  input  flags_t               flags_i,
  output logic [DataWidth-1:0] acc_o,
  output flags_t               flags_o
);

  logic                 cin;
  logic                 is_sub;
  logic [DataWidth:0]   full_res;
  logic [NibWidth:0]    nib_res;
  logic [DataWidth-1:0] daa_corr;
  logic                 daa_lo;
  logic                 daa_hi;

  // Shared adder/subtractor; bit 8 and bit 4 give carry or borrow
  always_comb begin
    cin    = 1'b0;
    is_sub = 1'b0;
    case (cmd_i)
      CMD_ADC: cin = flags_i.carry;
      CMD_SUB, CMD_CP: is_sub = 1'b1;
      CMD_SBC: begin
        cin    = flags_i.carry;
        is_sub = 1'b1;
      end
      default: ;
    endcase
    if (is_sub) begin
      full_res = {1'b0, acc_i} - {1'b0, operand_i} - {{DataWidth{1'b0}}, cin};
      nib_res  = {1'b0, acc_i[NibWidth-1:0]} - {1'b0, operand_i[NibWidth-1:0]}
                 - {{NibWidth{1'b0}}, cin};
    end else begin
      full_res = {1'b0, acc_i} + {1'b0, operand_i} + {{DataWidth{1'b0}}, cin};
      nib_res  = {1'b0, acc_i[NibWidth-1:0]} + {1'b0, operand_i[NibWidth-1:0]}
                 + {{NibWidth{1'b0}}, cin};
    end
  end

  // Decimal adjust corrections come from the accumulator and the flags before the operation
  assign daa_lo   = flags_i.half | (!flags_i.sub && (acc_i[NibWidth-1:0] > DaaLowMax));
  assign daa_hi   = flags_i.carry | (!flags_i.sub && (acc_i > DaaHighMax));
  assign daa_corr = (daa_lo ? DaaLowCorr : '0) | (daa_hi ? DaaHighCorr : '0);

  always_comb begin
    acc_o   = acc_i;
    flags_o = flags_i;
    unique case (cmd_i)
      CMD_ADD, CMD_ADC, CMD_SUB, CMD_SBC, CMD_CP: begin
        if (cmd_i != CMD_CP) begin
          acc_o = full_res[DataWidth-1:0];
        end
        flags_o.zero  = (full_res[DataWidth-1:0] == '0);
        flags_o.sub   = is_sub;
        flags_o.half  = nib_res[NibWidth];
        flags_o.carry = full_res[DataWidth];
      end
      CMD_AND, CMD_XOR, CMD_OR: begin
        if (cmd_i == CMD_AND) begin
          acc_o = acc_i & operand_i;
        end else if (cmd_i == CMD_XOR) begin
          acc_o = acc_i ^ operand_i;
        end else begin
          acc_o = acc_i | operand_i;
        end
        flags_o.zero  = (acc_o == '0);
        flags_o.sub   = 1'b0;
        flags_o.half  = (cmd_i == CMD_AND);
        flags_o.carry = 1'b0;
      end
      CMD_DAA: begin
        acc_o         = flags_i.sub ? (acc_i - daa_corr) : (acc_i + daa_corr);
        flags_o.zero  = (acc_o == '0);
        flags_o.half  = 1'b0;
        flags_o.carry = flags_i.carry | daa_hi;
      end
      CMD_CPL: begin
        acc_o        = ~acc_i;
        flags_o.sub  = 1'b1;
        flags_o.half = 1'b1;
      end
      CMD_SCF, CMD_CCF: begin
        flags_o.sub   = 1'b0;
        flags_o.half  = 1'b0;
        flags_o.carry = (cmd_i == CMD_SCF) ? 1'b1 : !flags_i.carry;
      end
      CMD_RLCA, CMD_RLA: begin
        acc_o = {acc_i[DataWidth-2:0],
                 (cmd_i == CMD_RLCA) ? acc_i[DataWidth-1] : flags_i.carry};
        flags_o = '{zero: 1'b0, sub: 1'b0, half: 1'b0, carry: acc_i[DataWidth-1]};
      end
      CMD_RRCA, CMD_RRA: begin
        acc_o = {(cmd_i == CMD_RRCA) ? acc_i[0] : flags_i.carry,
                 acc_i[DataWidth-1:1]};
        flags_o = '{zero: 1'b0, sub: 1'b0, half: 1'b0, carry: acc_i[0]};
      end
      CMD_LOAD: acc_o = operand_i;
      default: ;
    endcase
  end

endmodule

>>> hdl/accumulator_alu_with_flags.sv
// An accepted word waits in the input register, then commits into the state that drives the master side.
// Throughput: one word per cycle, sustained while the master side keeps tready high.
// The accumulator and flag registers double as the result register; the ALU is one
// pass of combinational logic between the input register and those registers.
// Reset (rst_ni low, asynchronous): accumulator and all four flags clear to zero,
// both pipeline slots empty.
module accumulator_alu_with_flags
  import aalu_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // s_tdata_i: [4:0] cmd, [12:5] operand_byte, [15:13] zero fill
  input  logic                     s_tvalid_i,
  output logic                     s_tready_o,
  input  logic [InTdataWidth-1:0]  s_tdata_i,
  // m_tdata_o: [7:0] acc_out, [8] zero_out, [9] sub_out, [10] half_out,
  //            [11] carry_out, [15:12] zero fill
  output logic                     m_tvalid_o,
  input  logic                     m_tready_i,
  output logic [OutTdataWidth-1:0] m_tdata_o
);

  // Input register: holds one accepted word until the ALU pass can commit it
  logic                 in_valid_q;
  logic [CmdWidth-1:0]  in_cmd_q;
  logic [DataWidth-1:0] in_operand_q;

  // Architectural state, also the visible result
  logic [DataWidth-1:0] acc_q, acc_d;
  flags_t               flags_q, flags_d;
  logic                 out_valid_q;

  logic out_free;
  logic advance;
  logic in_take;

  // The result slot is free when empty or being drained this cycle
  assign out_free   = !out_valid_q || m_tready_i;
  // Commit the staged word into state when the result slot can take it
  assign advance    = in_valid_q && out_free;
  // Take a new word whenever the staged one leaves (or none is staged)
  assign s_tready_o = !in_valid_q || advance;
  assign in_take    = s_tvalid_i && s_tready_o;

  aalu_exec u_exec (
    .cmd_i     (in_cmd_q),
    .operand_i (in_operand_q),
    .acc_i     (acc_q),
    .flags_i   (flags_q),
    .acc_o     (acc_d),
    .flags_o   (flags_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      flags_q     <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        acc_q       <= acc_d;
        flags_q     <= flags_d;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload of the input stage: load on accept, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q     <= s_tdata_i[CmdWidth-1:0];
      in_operand_q <= s_tdata_i[CmdWidth +: DataWidth];
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(OutTdataWidth - DataWidth - 4){1'b0}},
                       flags_q.carry, flags_q.half, flags_q.sub, flags_q.zero, acc_q};

`ifndef SYNTHESIS
  // A commit always leaves a result waiting on the master side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("commit did not present a result");

  // Back-pressure on the slave side only when a word is staged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> in_valid_q)
    else $error("slave side stalled with empty input stage");

  // Rotates always clear zero, subtract and half-carry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_cmd_q == CMD_RLCA || in_cmd_q == CMD_RLA ||
                in_cmd_q == CMD_RRCA || in_cmd_q == CMD_RRA)
    |=> !flags_q.zero && !flags_q.sub && !flags_q.half)
    else $error("rotate left stale flags");

  // Load copies the operand and keeps every flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_cmd_q == CMD_LOAD)
    |=> (acc_q == $past(in_operand_q)) && (flags_q == $past(flags_q)))
    else $error("load corrupted accumulator or flags");
`endif

endmodule
